FILE: hw/rtl/rmsprop_parameter_update_assert.svh
// Assertion macros used by the checker of this block.
// Each one clocks on clk and is disabled while rst_n is low.
`ifndef RMSPROP_PARAMETER_UPDATE_ASSERT_SVH
`define RMSPROP_PARAMETER_UPDATE_ASSERT_SVH

// same-cycle implication
`define RMSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define RMSP_ASSERT_DELAY(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rmsp_pkg.sv
package rmsp_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned LR_W       = 32;
  localparam int unsigned DECAY_W    = 16;
  localparam int unsigned SLOT_IDX_W = 4;
  localparam int unsigned MEAN_W     = 64;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SLOTS_DEF  = 16;

  localparam logic [LR_W-1:0]    LR_RESET    = 32'd4294967;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd58982;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR  = 1'd1;

  // sequencer lengths
  localparam int unsigned MAC_STEPS  = 7;
  localparam int unsigned ROOT_ITERS = 32;
  localparam int unsigned DIV_ITERS  = 48;
  // start transfer to result strobe
  localparam int unsigned ITEM_LAT   = MAC_STEPS + ROOT_ITERS + DIV_ITERS + 2;

endpackage

FILE: hw/rtl/rmsprop_parameter_update.sv
// One item at a time: start is taken only while busy is low, and busy stays
// high until the out_valid strobe. Each item runs 7 steps of the shared
// 32x32 multiplier, a 32-step square root and a 48-step divide, both on one
// shared 34-bit subtractor, then a final step that registers the result.
// Reset: config returns to defaults, then a pass over all SLOTS entries
// zeroes the mean store with busy high. The receiver cannot stall out_valid.
module rmsprop_parameter_update #(
  parameter int unsigned SLOTS = rmsp_pkg::SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [rmsp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rmsp_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [rmsp_pkg::SLOT_IDX_W-1:0]       in_slot_index,
  input  logic signed [rmsp_pkg::VALUE_W-1:0]   in_param_value,
  input  logic signed [rmsp_pkg::VALUE_W-1:0]   in_gradient,
  output logic                                  out_valid,
  output logic signed [rmsp_pkg::VALUE_W-1:0]   out_new_value,
  output logic                                  out_saturated
);
  import rmsp_pkg::*;

  localparam int unsigned AW         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SLOT_MAP_N = 2 ** SLOT_IDX_W;
  localparam int unsigned CNT_W      = $clog2(DIV_ITERS);
  localparam int unsigned ACC_W      = 82;
  localparam int unsigned QUO_W      = 48;
  localparam int unsigned RES_W      = QUO_W + 2;
  localparam int unsigned REM_W      = 34;

  // multiply-accumulate step codes
  localparam logic [CNT_W-1:0] STEP_GG      = CNT_W'(0);
  localparam logic [CNT_W-1:0] STEP_MEAN_LO = CNT_W'(1);
  localparam logic [CNT_W-1:0] STEP_MEAN_HI = CNT_W'(2);
  localparam logic [CNT_W-1:0] STEP_GG_LO   = CNT_W'(3);
  localparam logic [CNT_W-1:0] STEP_GG_HI   = CNT_W'(4);
  localparam logic [CNT_W-1:0] STEP_NUM     = CNT_W'(5);
  localparam logic [CNT_W-1:0] STEP_DONE    = CNT_W'(MAC_STEPS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_MAC, ST_ROOT, ST_DIV, ST_FIN
  } state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [AW-1:0]           clr_addr_r;
  logic [LR_W-1:0]         lr_r;
  logic [DECAY_W-1:0]      decay_r;
  logic [AW-1:0]           slot_r;
  logic [VALUE_W-1:0]      value_r;
  logic [VALUE_W-1:0]      gmag_r;
  logic                    gneg_r;
  logic [MEAN_W-1:0]       prod_r;
  logic [MEAN_W-1:0]       gg_r;
  logic [ACC_W-1:0]        acc_r;
  logic [MEAN_W-1:0]       work_r;
  logic [REM_W-1:0]        rem_r;
  logic [VALUE_W-1:0]      root_r;
  logic [VALUE_W:0]        div_r;
  logic                    sat_r;
  logic                    out_valid_r;
  logic [VALUE_W-1:0]      out_value_r;
  logic                    out_sat_r;

  logic [AW-1:0]           slot_map [SLOT_MAP_N];
  logic                    accept;
  logic [VALUE_W-1:0]      in_gmag;
  logic [MEAN_W-1:0]       mean_rd;
  logic [DECAY_W:0]        weight;
  logic [VALUE_W-1:0]      mul_a;
  logic [VALUE_W-1:0]      mul_b;
  logic [MEAN_W-1:0]       mul_p;
  logic [ACC_W-1:0]        acc_nxt;
  logic                    mean_ovf;
  logic [MEAN_W-1:0]       mean_nxt;
  logic [REM_W-1:0]        sub_a;
  logic [REM_W-1:0]        sub_b;
  logic [REM_W:0]          diff;
  logic                    ge;
  logic [VALUE_W-1:0]      root_nxt;
  logic signed [RES_W-1:0] res;
  logic                    res_ovf;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [MEAN_W-1:0]       ram_wdata;

  // slot_index mod SLOTS, built at elaboration
  for (genvar i = 0; i < SLOT_MAP_N; i++) begin : g_slot_map
    assign slot_map[i] = AW'(i % SLOTS);
  end

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  assign in_gmag = in_gradient[VALUE_W-1] ? (~in_gradient + VALUE_W'(1)) : in_gradient;
  assign weight  = 17'h10000 - {1'b0, decay_r};

  // shared multiplier; prod_r always holds the previous step's product
  always_comb begin
    unique case (cnt_r)
      STEP_GG: begin
        mul_a = gmag_r;
        mul_b = gmag_r;
      end
      STEP_MEAN_LO: begin
        mul_a = VALUE_W'(decay_r);
        mul_b = mean_rd[31:0];
      end
      STEP_MEAN_HI: begin
        mul_a = VALUE_W'(decay_r);
        mul_b = mean_rd[63:32];
      end
      STEP_GG_LO: begin
        mul_a = VALUE_W'(weight);
        mul_b = gg_r[31:0];
      end
      STEP_GG_HI: begin
        mul_a = VALUE_W'(weight);
        mul_b = gg_r[63:32];
      end
      STEP_NUM: begin
        mul_a = lr_r;
        mul_b = gmag_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    unique case (cnt_r)
      STEP_MEAN_HI: acc_nxt = ACC_W'(prod_r);
      STEP_GG_LO:   acc_nxt = acc_r + ACC_W'({prod_r, 32'd0});
      STEP_GG_HI:   acc_nxt = acc_r + ACC_W'(prod_r);
      STEP_NUM:     acc_nxt = acc_r + ACC_W'({prod_r, 32'd0});
      default:      acc_nxt = acc_r;
    endcase
  end

  // acc_r holds d*mean + (1-d)*g*g in Q34.48
  assign mean_ovf = |acc_r[ACC_W-1:80];
  assign mean_nxt = mean_ovf ? '1 : acc_r[79:16];

  // shared subtractor: root trial in ST_ROOT, divisor compare in ST_DIV
  always_comb begin
    if (state_r == ST_ROOT) begin
      sub_a = {rem_r[31:0], work_r[63:62]};
      sub_b = {root_r, 2'b01};
    end else begin
      sub_a = {rem_r[32:0], work_r[QUO_W-1]};
      sub_b = {1'b0, div_r};
    end
  end

  assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge       = ~diff[REM_W];
  assign root_nxt = {root_r[VALUE_W-2:0], ge};

  assign res = gneg_r ?
    (RES_W'($signed(value_r)) + $signed({2'b00, work_r[QUO_W-1:0]})) :
    (RES_W'($signed(value_r)) - $signed({2'b00, work_r[QUO_W-1:0]}));
  assign res_ovf = !((&res[RES_W-1:VALUE_W-1]) || !(|res[RES_W-1:VALUE_W-1]));

  assign ram_we    = (state_r == ST_CLEAR) || (state_r == ST_MAC && cnt_r == STEP_DONE);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_addr_r : slot_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : mean_nxt;

  rmsp_ram #(
    .WIDTH (MEAN_W),
    .DEPTH (SLOTS)
  ) u_mean_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (slot_map[in_slot_index]),
    .rdata (mean_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      clr_addr_r  <= '0;
      lr_r        <= LR_RESET;
      decay_r     <= DECAY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LEARNING_RATE: lr_r    <= cfg_data[LR_W-1:0];
          CFG_DECAY_FACTOR:  decay_r <= cfg_data[DECAY_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(SLOTS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            slot_r  <= slot_map[in_slot_index];
            value_r <= in_param_value;
            gmag_r  <= in_gmag;
            gneg_r  <= in_gradient[VALUE_W-1];
            cnt_r   <= '0;
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (cnt_r != STEP_DONE) begin
            prod_r <= mul_p;
          end
          if (cnt_r == STEP_MEAN_LO) begin
            gg_r <= prod_r;
          end
          acc_r <= acc_nxt;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == STEP_DONE) begin
            work_r  <= mean_nxt;
            rem_r   <= '0;
            root_r  <= '0;
            sat_r   <= mean_ovf;
            cnt_r   <= '0;
            state_r <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          rem_r  <= ge ? diff[REM_W-1:0] : sub_a;
          root_r <= root_nxt;
          work_r <= {work_r[MEAN_W-3:0], 2'b00};
          cnt_r  <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(ROOT_ITERS - 1)) begin
            // divide (lr*|g| >> 16) by root + 1
            div_r   <= {1'b0, root_nxt} + (VALUE_W + 1)'(1);
            rem_r   <= '0;
            work_r  <= MEAN_W'(prod_r[MEAN_W-1:16]);
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r  <= ge ? diff[REM_W-1:0] : sub_a;
          work_r <= {work_r[MEAN_W-2:0], ge};
          cnt_r  <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_ITERS - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (res_ovf) begin
            out_value_r <= res[RES_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                        : {1'b0, {(VALUE_W-1){1'b1}}};
          end else begin
            out_value_r <= res[VALUE_W-1:0];
          end
          out_sat_r   <= sat_r | res_ovf;
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_value = out_value_r;
  assign out_saturated = out_sat_r;

endmodule

FILE: hw/rtl/rmsp_ram.sv
module rmsp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/rmsp_checker.sv
`include "rmsprop_parameter_update_assert.svh"

module rmsp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import rmsp_pkg::*;

  `RMSP_ASSERT_IMP(a_result_when_idle, out_valid, !busy, "result strobe while busy")
  `RMSP_ASSERT_NEXT(a_start_takes_block, start && !busy, busy && !out_valid, "start not taken")
  `RMSP_ASSERT_DELAY(a_fixed_latency, start && !busy, ITEM_LAT, out_valid, "result late or missing")
  `RMSP_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than a cycle")

endmodule

bind rmsprop_parameter_update rmsp_checker u_rmsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

FILE: tb/tb_rmsprop_parameter_update.sv
`timescale 1ns / 100ps

module tb_rmsprop_parameter_update;
  import rmsp_pkg::*;

  localparam int unsigned NUM_SLOTS     = SLOTS_DEF;
  localparam int unsigned SETTLE_CYCLES = 2;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned ITEMS_PER_PH  = 185;
  localparam logic signed [65:0] Q16_MAX = 66'sd2147483647;
  localparam logic signed [65:0] Q16_MIN = -66'sd2147483648;

  typedef enum logic [1:0] {REQ_ITEM, REQ_CFG_WRITE, REQ_DRAIN} req_kind_t;

  typedef struct {
    req_kind_t               kind;
    logic [SLOT_IDX_W-1:0]   slot;
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] grad;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_data;
  } req_t;

  typedef struct {
    logic signed [VALUE_W-1:0] new_value;
    logic                      saturated;
  } update_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic [SLOT_IDX_W-1:0] in_slot_index = '0;
  logic signed [VALUE_W-1:0] in_param_value = '0;
  logic signed [VALUE_W-1:0] in_gradient = '0;
  logic out_valid;
  logic signed [VALUE_W-1:0] out_new_value;
  logic out_saturated;

  // predictor state
  logic [LR_W-1:0]    lr_cfg = LR_RESET;
  logic [DECAY_W-1:0] decay_cfg = DECAY_RESET;
  logic [MEAN_W-1:0]  sq_grad_mean [NUM_SLOTS];

  req_t    cmd_q[$];
  update_t exp_updates[$];
  req_t    cur;
  logic    presenting = 1'b0;
  int      quiet_cycles = 0;
  int      items_sent = 0;
  int      stall_cycles = 0;
  int      fail_count = 0;

  rmsprop_parameter_update uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .in_slot_index  (in_slot_index),
    .in_param_value (in_param_value),
    .in_gradient    (in_gradient),
    .out_valid      (out_valid),
    .out_new_value  (out_new_value),
    .out_saturated  (out_saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Updates the slot's squared-gradient mean and returns the stepped value.
  function automatic update_t predict_update(input logic [SLOT_IDX_W-1:0] slot,
                                             input logic signed [VALUE_W-1:0] value,
                                             input logic signed [VALUE_W-1:0] grad);
    int unsigned sidx;
    logic [31:0] gmag;
    logic [63:0] grad_sq;
    logic [16:0] keep_w;
    logic [16:0] new_w;
    logic [80:0] prod_old;
    logic [80:0] prod_new;
    logic [63:0] ip_old;
    logic [63:0] ip_new;
    logic [16:0] frac;
    logic [65:0] sum;
    logic [63:0] mean;
    logic [31:0] root;
    logic [31:0] trial;
    logic [63:0] step;
    logic signed [65:0] wide_val;
    logic signed [65:0] step_s;
    logic signed [65:0] wide_res;
    logic clip;
    update_t r;
    clip = 1'b0;
    sidx = slot % NUM_SLOTS;
    gmag = grad[31] ? (~grad + 32'd1) : grad;
    grad_sq = 64'(gmag) * 64'(gmag);
    keep_w = {1'b0, decay_cfg};
    new_w = 17'h10000 - keep_w;
    prod_old = 81'(keep_w) * 81'(sq_grad_mean[sidx]);
    prod_new = 81'(new_w) * 81'(grad_sq);
    ip_old = prod_old[80] ? '1 : prod_old[79:16];
    ip_new = prod_new[80] ? '1 : prod_new[79:16];
    clip = prod_old[80] | prod_new[80];
    sum = 66'(ip_old) + 66'(ip_new);
    if (sum[64]) begin
      sum = 66'(64'hFFFF_FFFF_FFFF_FFFF);
      clip = 1'b1;
    end
    // carry out of the two discarded fractions
    frac = 17'(prod_old[15:0]) + 17'(prod_new[15:0]);
    sum = sum + 66'(frac[16]);
    if (sum[64]) begin
      mean = '1;
      clip = 1'b1;
    end else begin
      mean = sum[63:0];
    end
    sq_grad_mean[sidx] = mean;

    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (64'(trial) * 64'(trial) <= mean) root = trial;
    end
    step = (64'(lr_cfg) * 64'(gmag)) / ((64'(root) + 64'd1) << 16);

    wide_val = 66'(value);
    step_s = {2'b00, step};
    wide_res = grad[31] ? wide_val + step_s : wide_val - step_s;
    if (wide_res > Q16_MAX) begin
      wide_res = Q16_MAX;
      clip = 1'b1;
    end else if (wide_res < Q16_MIN) begin
      wide_res = Q16_MIN;
      clip = 1'b1;
    end
    r.new_value = wide_res[31:0];
    r.saturated = clip;
    return r;
  endfunction

  task automatic add_item(input logic [SLOT_IDX_W-1:0] slot,
                          input logic signed [VALUE_W-1:0] value,
                          input logic signed [VALUE_W-1:0] grad);
    req_t q;
    q = '{REQ_ITEM, slot, value, grad, '0, '0};
    cmd_q.insert(cmd_q.size(), q);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    req_t q;
    q = '{REQ_CFG_WRITE, '0, '0, '0, idx, data};
    cmd_q.insert(cmd_q.size(), q);
  endtask

  task automatic add_drain();
    req_t q;
    q = '{REQ_DRAIN, '0, '0, '0, '0, '0};
    cmd_q.insert(cmd_q.size(), q);
  endtask

  // driver
  always @(posedge clk) begin
    logic next_we;
    logic gaps_on;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      presenting = 1'b0;
      quiet_cycles = 0;
    end else begin
      if (start && !busy) begin
        exp_updates.insert(exp_updates.size(),
                           predict_update(in_slot_index, in_param_value, in_gradient));
        presenting = 1'b0;
        items_sent++;
      end
      // block idle and nothing in flight
      if (exp_updates.size() == 0 && !busy && !presenting) quiet_cycles++;
      else quiet_cycles = 0;
      next_we = 1'b0;
      if (!presenting && cmd_q.size() != 0) begin
        case (cmd_q[0].kind)
          REQ_ITEM: begin
            cur = cmd_q.pop_front();
            presenting = 1'b1;
            in_slot_index <= cur.slot;
            in_param_value <= cur.value;
            in_gradient <= cur.grad;
          end
          REQ_CFG_WRITE: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              cur = cmd_q.pop_front();
              next_we = 1'b1;
              cfg_index <= cur.reg_idx;
              cfg_data <= cur.reg_data;
              if (cur.reg_idx == CFG_LEARNING_RATE) lr_cfg = cur.reg_data;
              else decay_cfg = cur.reg_data[DECAY_W-1:0];
            end
          end
          default: begin
            if (quiet_cycles >= SETTLE_CYCLES) void'(cmd_q.pop_front());
          end
        endcase
      end
      cfg_we <= next_we;
      gaps_on = !(items_sent >= 500 && items_sent < 750);
      start <= presenting && !(gaps_on && $urandom_range(99) < 14);
    end
  end

  // monitor
  always @(posedge clk) begin
    update_t exp_upd;
    if (rst_n) begin
      if (out_valid) begin
        if (exp_updates.size() == 0) begin
          $error("result with no pending update: new_value %0d saturated %0b",
                 out_new_value, out_saturated);
          fail_count++;
        end else begin
          exp_upd = exp_updates.pop_front();
          if (out_new_value !== exp_upd.new_value) begin
            $error("new_value: expected %0d, got %0d", exp_upd.new_value, out_new_value);
            fail_count++;
          end
          if (out_saturated !== exp_upd.saturated) begin
            $error("saturated: expected %0b, got %0b", exp_upd.saturated, out_saturated);
            fail_count++;
          end
        end
      end
      if (out_valid || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic signed [VALUE_W-1:0] v;
    logic signed [VALUE_W-1:0] g;
    logic [LR_W-1:0] lr;
    logic [CFG_DATA_W-1:0] dk;
    for (int s = 0; s < NUM_SLOTS; s++) sq_grad_mean[s] = '0;

    // default rates: extremes, zero gradient, repeated slot
    add_item(4'd0, 32'sh0000_0000, 32'sh0000_0000);
    add_item(4'd15, 32'sh7FFF_FFFF, 32'sh8000_0000);
    add_item(4'd15, 32'sh8000_0000, 32'sh7FFF_FFFF);
    add_item(4'd3, 32'sh1234_5678, 32'shFFFF_FFFF);
    add_item(4'd3, 32'shEDCB_A988, 32'sh0000_0001);
    add_item(4'd7, 32'shFFFF_FFFF, 32'sh0001_0000);
    add_item(4'd15, 32'sh0000_0000, 32'sh0000_0000);
    add_drain();
    // max rate, slowest decay: result clips both ways
    add_write(CFG_LEARNING_RATE, 32'hFFFF_FFFF);
    add_write(CFG_DECAY_FACTOR, 32'd65535);
    add_item(4'd1, 32'sh7FFF_FFF0, 32'shFFFF_0000);
    add_item(4'd2, 32'sh8000_0010, 32'sh0001_0000);
    add_item(4'd4, 32'sh0000_0000, 32'sh0000_0001);
    add_item(4'd5, 32'sh0001_0000, 32'sh8000_0000);
    add_item(4'd5, 32'sh0000_0000, 32'sh7FFF_FFFF);
    add_drain();
    // zero rate, no decay; upper data bits ignored by the decay register
    add_write(CFG_LEARNING_RATE, 32'h0000_0000);
    add_write(CFG_DECAY_FACTOR, 32'hFFFF_0000);
    add_item(4'd6, 32'sh7FFF_FFFF, 32'sh8000_0000);
    add_item(4'd6, 32'sh8000_0000, 32'sh7FFF_FFFF);
    add_item(4'd8, 32'sh5555_5555, 32'shAAAA_AAAA);
    add_item(4'd9, 32'shAAAA_AAAA, 32'sh5555_5555);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin lr = LR_RESET; dk = 32'(DECAY_RESET); end
        1: begin lr = '1; dk = 32'd0; end
        2: begin lr = $urandom(); dk = $urandom_range(65535); end
        3: begin lr = '0; dk = 32'd65535; end
        4: begin lr = $urandom_range(1 << 24); dk = $urandom(); end
        default: begin lr = '1; dk = 32'(DECAY_RESET); end
      endcase
      add_drain();
      add_write(CFG_LEARNING_RATE, lr);
      add_write(CFG_DECAY_FACTOR, dk);
      for (int k = 0; k < ITEMS_PER_PH; k++) begin
        case ($urandom_range(3))
          0: v = $urandom();
          1: v = 32'sh7FFF_FFFF - $urandom_range(1 << 20);
          2: v = 32'sh8000_0000 + $urandom_range(1 << 20);
          default: v = $signed($urandom_range(1 << 21)) - 32'sd1048576;
        endcase
        case ($urandom_range(4))
          0: g = $urandom();
          1: begin
            g = $urandom_range(1 << 17);
            if ($urandom_range(1)) g = -g;
          end
          2: g = '0;
          3: begin
            case ($urandom_range(3))
              0: g = 32'sh7FFF_FFFF;
              1: g = 32'sh8000_0000;
              2: g = 32'sh0000_0001;
              default: g = 32'shFFFF_FFFF;
            endcase
          end
          default: begin
            g = $urandom_range(1 << 26);
            if ($urandom_range(1)) g = -g;
          end
        endcase
        add_item(SLOT_IDX_W'($urandom_range(NUM_SLOTS - 1)), v, g);
        // sender holds off until the block has drained
        if ($urandom_range(59) == 0) add_drain();
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || presenting || exp_updates.size() != 0) @(posedge clk);
    repeat (ITEM_LAT + 16) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/rmsp_pkg.sv
hw/rtl/rmsp_ram.sv
hw/rtl/rmsprop_parameter_update.sv
hw/rtl/rmsp_checker.sv
tb/tb_rmsprop_parameter_update.sv
